// ===== design/vector_angle_degrees_defines.svh =====
// Assertion helpers shared by the vector angle block.
`ifndef VECTOR_ANGLE_DEGREES_DEFINES_SVH
`define VECTOR_ANGLE_DEGREES_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define VAD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define VAD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/vad_pkg.sv =====
`default_nettype none

package vad_pkg;

  // Field widths and fixed-point formats
  localparam int unsigned COORD_WIDTH    = 16;
  localparam int unsigned GUARD_BITS     = 8;
  localparam int unsigned DATA_WIDTH     = COORD_WIDTH + GUARD_BITS + 3;
  localparam int unsigned ACC_WIDTH      = 27;
  localparam int unsigned ANGLE_WIDTH    = 16;
  localparam int unsigned FRAC_DROP      = 9;
  localparam int unsigned TAB_LEN        = 24;
  localparam int unsigned STAGES_DEFAULT = 16;

  // Exact angles for axis vectors, 1/128 degree units
  localparam logic [ANGLE_WIDTH-1:0] ANG_0   = 16'd0;
  localparam logic [ANGLE_WIDTH-1:0] ANG_90  = 16'd11520;
  localparam logic [ANGLE_WIDTH-1:0] ANG_180 = 16'd23040;
  localparam logic [ANGLE_WIDTH-1:0] ANG_270 = 16'd34560;
  localparam int unsigned            OUT_FULL_TURN = 46080;

  // Accumulator constants, 1/65536 degree units
  localparam logic signed [ACC_WIDTH-1:0] ACC_HALF_TURN = 27'sd11796480;
  localparam logic signed [ACC_WIDTH-1:0] ACC_FULL_TURN = 27'sd23592960;
  localparam logic signed [ACC_WIDTH-1:0] ACC_ROUND     = 27'sd256;

  // atan(2^-i) in degrees * 65536
  localparam logic signed [ACC_WIDTH-1:0] ATAN_TAB [TAB_LEN] = '{
    27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
    27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
    27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
    27'sd917,     27'sd458,     27'sd229,    27'sd115,
    27'sd57,      27'sd29,      27'sd14,     27'sd7,
    27'sd4,       27'sd2,       27'sd1,      27'sd0
  };

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vec_x;
    logic signed [COORD_WIDTH-1:0] vec_y;
  } vad_in_t;

  typedef struct packed {
    logic [ANGLE_WIDTH-1:0] angle;
    logic                   at_origin;
  } vad_out_t;

  // Per-transaction state handed from cell to cell
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] cx;
    logic signed [DATA_WIDTH-1:0] cy;
    logic signed [ACC_WIDTH-1:0]  acc;
    logic                         fixed;
    logic [ANGLE_WIDTH-1:0]       fixed_angle;
    logic                         at_origin;
  } vad_work_t;

endpackage

`default_nettype wire

// ===== design/vad_prep.sv =====
`default_nettype none

module vad_prep (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  output logic                ready_o,
  input  vad_pkg::vad_in_t    data_i,
  output logic                valid_o,
  input  wire                 ready_i,
  output vad_pkg::vad_work_t  data_o
);
  import vad_pkg::*;

  logic signed [DATA_WIDTH-1:0] x_ext, y_ext, neg_x, neg_y;
  logic                         x_zero, y_zero, x_neg, y_neg;
  logic                         valid_q;
  vad_work_t                    data_d, data_q;

  // Sign extension and axis detection
  always_comb begin
    x_ext  = {{(DATA_WIDTH-COORD_WIDTH){data_i.vec_x[COORD_WIDTH-1]}}, data_i.vec_x};
    y_ext  = {{(DATA_WIDTH-COORD_WIDTH){data_i.vec_y[COORD_WIDTH-1]}}, data_i.vec_y};
    neg_x  = -x_ext;
    neg_y  = -y_ext;
    x_zero = (data_i.vec_x == '0);
    y_zero = (data_i.vec_y == '0);
    x_neg  = data_i.vec_x[COORD_WIDTH-1];
    y_neg  = data_i.vec_y[COORD_WIDTH-1];
  end

  // Flip y to math convention, fold left half plane by 180 degrees
  always_comb begin
    data_d.at_origin = x_zero && y_zero;
    data_d.fixed     = x_zero || y_zero;
    if (x_zero && y_zero) begin
      data_d.fixed_angle = ANG_0;
    end else if (x_zero) begin
      data_d.fixed_angle = y_neg ? ANG_90 : ANG_270;
    end else if (x_neg) begin
      data_d.fixed_angle = ANG_180;
    end else begin
      data_d.fixed_angle = ANG_0;
    end
    if (x_neg) begin
      data_d.cx  = neg_x <<< GUARD_BITS;
      data_d.cy  = y_ext <<< GUARD_BITS;
      data_d.acc = ACC_HALF_TURN;
    end else begin
      data_d.cx  = x_ext <<< GUARD_BITS;
      data_d.cy  = neg_y <<< GUARD_BITS;
      data_d.acc = '0;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/vad_cell.sv =====
`default_nettype none

module vad_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  output logic                ready_o,
  input  vad_pkg::vad_work_t  data_i,
  output logic                valid_o,
  input  wire                 ready_i,
  output vad_pkg::vad_work_t  data_o
);
  import vad_pkg::*;

  localparam logic signed [ACC_WIDTH-1:0] ATAN_STEP = ATAN_TAB[IDX];

  logic signed [DATA_WIDTH-1:0] cx, cy, dx, dy;
  logic                         valid_q;
  vad_work_t                    data_d, data_q;

  // One micro-rotation toward the x axis
  always_comb begin
    cx     = data_i.cx;
    cy     = data_i.cy;
    dx     = cy >>> IDX;
    dy     = cx >>> IDX;
    data_d = data_i;
    if (!cy[DATA_WIDTH-1]) begin
      data_d.cx  = cx + dx;
      data_d.cy  = cy - dy;
      data_d.acc = data_i.acc + ATAN_STEP;
    end else begin
      data_d.cx  = cx - dx;
      data_d.cy  = cy + dy;
      data_d.acc = data_i.acc - ATAN_STEP;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/vad_post.sv =====
`default_nettype none

module vad_post (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  output logic                ready_o,
  input  vad_pkg::vad_work_t  data_i,
  output logic                valid_o,
  input  wire                 ready_i,
  output vad_pkg::vad_out_t   data_o
);
  import vad_pkg::*;

  localparam int unsigned DEG_WIDTH = ACC_WIDTH - FRAC_DROP;

  logic signed [ACC_WIDTH-1:0] acc_wrap, acc_rnd;
  logic [DEG_WIDTH-1:0]        deg, deg_fold;
  logic                        valid_q;
  vad_out_t                    data_d, data_q;

  // Fold to [0, 360), round to 1/128 degree, wrap a full turn to zero
  always_comb begin
    acc_wrap = data_i.acc[ACC_WIDTH-1] ? (data_i.acc + ACC_FULL_TURN) : data_i.acc;
    acc_rnd  = acc_wrap + ACC_ROUND;
    deg      = acc_rnd[ACC_WIDTH-1:FRAC_DROP];
    deg_fold = (deg >= DEG_WIDTH'(OUT_FULL_TURN)) ? (deg - DEG_WIDTH'(OUT_FULL_TURN)) : deg;
    data_d.at_origin = data_i.at_origin;
    data_d.angle     = data_i.fixed ? data_i.fixed_angle : deg_fold[ANGLE_WIDTH-1:0];
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/vector_angle_degrees.sv =====
// Direction angle of a screen-space vector (y grows downward): atan2(-y, x) in
// 1/128 degree steps, folded into 0..46079, by an unrolled CORDIC in vectoring
// mode. One vector is taken every clock cycle while in_ready_o is high. Each
// vector is registered in the input cell, then in one cell per micro-rotation
// (STAGES of them, at most TAB_LEN), then in one rounding cell that also holds
// the result, and it waits while out_ready_i is low. Each cell registers its
// transaction and frees itself when its neighbor takes it, so bubbles close up
// under back-pressure. The origin gives angle 0 with at_origin set; axis vectors
// give exact multiples of 90 degrees.
`default_nettype none

module vector_angle_degrees #(
  parameter int unsigned STAGES = vad_pkg::STAGES_DEFAULT
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  vad_pkg::vad_in_t   in_data_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output vad_pkg::vad_out_t  out_data_o
);
  import vad_pkg::*;
  `include "vector_angle_degrees_defines.svh"

  // Rotations beyond the table are not run
  localparam int unsigned RUN = (STAGES < TAB_LEN) ? STAGES : TAB_LEN;

  vad_work_t     stage_data [RUN+1];
  logic [RUN:0]  stage_valid;
  logic [RUN:0]  stage_ready;

  vad_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (stage_valid[0]),
    .ready_i (stage_ready[0]),
    .data_o  (stage_data[0])
  );

  // Chain of rotation cells
  for (genvar g = 0; g < RUN; g++) begin : g_cell
    vad_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[g]),
      .ready_o (stage_ready[g]),
      .data_i  (stage_data[g]),
      .valid_o (stage_valid[g+1]),
      .ready_i (stage_ready[g+1]),
      .data_o  (stage_data[g+1])
    );
  end

  vad_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_valid[RUN]),
    .ready_o (stage_ready[RUN]),
    .data_i  (stage_data[RUN]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

  // Checks
  `VAD_ASSERT_NOW(a_ready_when_drained, clk_i, rst_ni,
                  (!out_valid_o || out_ready_i), in_ready_o,
                  "input stalled although output side can move")
  `VAD_ASSERT_NEXT(a_accept_loads_prep, clk_i, rst_ni,
                   (in_valid_i && in_ready_o), stage_valid[0],
                   "accepted transaction missing from input cell")
  `VAD_ASSERT_NOW(a_angle_range, clk_i, rst_ni, out_valid_o,
                  ((out_data_o.angle < ANGLE_WIDTH'(OUT_FULL_TURN)) &&
                   (!out_data_o.at_origin || (out_data_o.angle == ANG_0))),
                  "angle out of range or nonzero at origin")

endmodule

`default_nettype wire

// ===== verif/vad_angle_checker.sv =====
// Watches both channels of the vector angle block, works out the expected
// angle of each accepted vector and compares every result against it in order.
module vad_angle_checker
  import vad_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  vad_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  vad_out_t    out_data_i,
  output int unsigned errors_o,
  output int unsigned outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROTATIONS = STAGES_DEFAULT;
  localparam int          ATAN_ENTRIES = 24;
  localparam longint      DEG_Q16 = 65536;
  localparam longint      FULL_TURN_OUT = 46080;

  // atan(2^-i) in degrees, 16 fractional bits
  localparam longint ATAN_DEG_Q16 [ATAN_ENTRIES] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  vad_out_t    pending_angles [$];
  vad_out_t    want;
  int unsigned mismatch_count = 0;

  initial outstanding_o = 0;
  assign errors_o = mismatch_count;

  // Direction angle of one screen vector: atan2(-y, x), 1/128 degree steps
  function automatic vad_out_t direction_of(vad_in_t v);
    longint   x;
    longint   y;
    longint   cx;
    longint   cy;
    longint   acc;
    longint   dx;
    longint   dy;
    longint   rounded;
    vad_out_t r;
    x = longint'($signed(v.vec_x));
    y = longint'($signed(v.vec_y));
    r.angle = ANG_0;
    r.at_origin = 1'b0;
    // origin and axis vectors are exact
    if (x == 0 && y == 0) begin
      r.at_origin = 1'b1;
      return r;
    end
    if (x == 0) begin
      r.angle = (y < 0) ? ANG_90 : ANG_270;
      return r;
    end
    if (y == 0) begin
      r.angle = (x > 0) ? ANG_0 : ANG_180;
      return r;
    end
    // flip left half plane into the right one, screen y is negated
    cx = x * 256;
    cy = -y * 256;
    acc = 0;
    if (cx < 0) begin
      cx = -cx;
      cy = -cy;
      acc = 180 * DEG_Q16;
    end
    // vectoring micro-rotations drive cy toward zero
    for (int i = 0; i < ROTATIONS && i < ATAN_ENTRIES; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx = cx + dx;
        cy = cy - dy;
        acc = acc + ATAN_DEG_Q16[i];
      end else begin
        cx = cx - dx;
        cy = cy + dy;
        acc = acc - ATAN_DEG_Q16[i];
      end
    end
    if (acc < 0) acc = acc + 360 * DEG_Q16;
    // round half up to 1/128 degree, fold a full turn back to zero
    rounded = (acc + 256) >>> 9;
    if (rounded >= FULL_TURN_OUT) rounded = rounded - FULL_TURN_OUT;
    r.angle = rounded[15:0];
    return r;
  endfunction

  // Queue expectations on input transactions, check on output transactions
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) pending_angles.push_back(direction_of(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (pending_angles.size() == 0) begin
          $error("unexpected result: angle %0d at_origin %0b",
                 out_data_i.angle, out_data_i.at_origin);
          mismatch_count++;
        end else begin
          want = pending_angles.pop_front();
          if (out_data_i.angle !== want.angle) begin
            $error("angle: expected %0d, actual %0d", want.angle, out_data_i.angle);
            mismatch_count++;
          end
          if (out_data_i.at_origin !== want.at_origin) begin
            $error("at_origin: expected %0b, actual %0b",
                   want.at_origin, out_data_i.at_origin);
            mismatch_count++;
          end
        end
      end
      outstanding_o <= pending_angles.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
// Drives vectors into the angle block with random gaps and back-pressure;
// the checker beside it does the prediction and comparison.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vad_pkg::*;

  localparam int          RANDOM_VECTORS = 1950;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          SETTLE_CYCLES = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  vad_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  vad_out_t    out_data_o;
  logic        free_running = 1'b0;
  int unsigned errors;
  int unsigned outstanding;
  int unsigned cycles = 0;

  vector_angle_degrees dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  vad_angle_checker checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_i    (out_data_o),
    .errors_o      (errors),
    .outstanding_o (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 0;
  end

  // Receiver stalls about one cycle in nine, never while free running
  always @(posedge clk_i) begin
    out_ready_i <= free_running || ($urandom_range(99) >= 11);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // One input transaction, then an occasional gap
  task automatic send_xy(input int x, input int y);
    vad_in_t item;
    item.vec_x = x[15:0];
    item.vec_y = y[15:0];
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (!in_ready_o);
    if (!free_running && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk_i);
    end
  endtask

  // Hold the sender until every expected result has arrived
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  initial begin
    int corner_x [22] = '{0, 0, 0, 0, 0, 1, -1, 32767, -32768, 32767, -32768,
                          -32768, 32767, 1, -1, -1, 1, 1, -32768, 32767, -1, -32768};
    int corner_y [22] = '{0, -1, 1, -32768, 32767, 0, 0, 0, 0, -32767, -32768,
                          32767, 32767, -1, 1, -1, 1, -32768, 1, -1, 32767, -1};
    int extreme_vals [6] = '{-32768, -32767, -1, 0, 1, 32767};
    int x;
    int y;
    int r;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Origin, both axes, full-scale corners and unit diagonals
    for (int i = 0; i < 22; i++) send_xy(corner_x[i], corner_y[i]);
    wait_drained();

    for (int n = 0; n < RANDOM_VECTORS; n++) begin
      if (n == 700) free_running <= 1'b1;
      if (n == 1100) free_running <= 1'b0;
      if (n % 500 == 499) wait_drained();
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          x = int'($urandom);
          y = int'($urandom);
        end
        4, 5: begin
          x = int'($urandom_range(16)) - 8;
          y = int'($urandom_range(16)) - 8;
        end
        6: begin
          // close to an axis
          x = int'($urandom);
          y = int'($urandom_range(4)) - 2;
          if ($urandom_range(1)) begin
            r = x;
            x = y;
            y = r;
          end
        end
        7: begin
          // close to a diagonal
          r = int'($urandom_range(32767));
          x = $urandom_range(1) ? r : -r;
          y = ($urandom_range(1) ? r : -r) + int'($urandom_range(4)) - 2;
        end
        8: begin
          x = extreme_vals[$urandom_range(5)];
          y = extreme_vals[$urandom_range(5)];
        end
        default: begin
          x = (1 << $urandom_range(14)) * ($urandom_range(1) ? 1 : -1);
          y = (1 << $urandom_range(14)) * ($urandom_range(1) ? 1 : -1);
        end
      endcase
      send_xy(x, y);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/vad_pkg.sv
design/vad_prep.sv
design/vad_cell.sv
design/vad_post.sv
design/vector_angle_degrees.sv
verif/vad_angle_checker.sv
verif/tb.sv
